// ===== rtl/qeeu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qeeu_pkg: shared types and constants of the quadrature encoder event unit
// Codes, widths, reset values and the Gray-code step decode.
// ----------------------------------------------------------------------------
package qeeu_pkg;

    // Elapsed-time counters
    localparam int ELAPSED_BITS = 10;
    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

    // Register widths
    localparam int STEPS_W    = 3;
    localparam int GLITCH_W   = 8;
    localparam int DEBOUNCE_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Window compare width: wide enough for the counter and either window
    localparam int CMP_W = (ELAPSED_BITS > DEBOUNCE_W) ? ELAPSED_BITS : DEBOUNCE_W;

    // Accumulator width
    localparam int ACC_W = 4;

    // Input kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_SWITCH = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    // Event codes
    localparam logic [1:0] EVT_EMPTY  = 2'd0;
    localparam logic [1:0] EVT_CW     = 2'd1;
    localparam logic [1:0] EVT_CCW    = 2'd2;
    localparam logic [1:0] EVT_BUTTON = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_DETENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd3;

    // Register reset values
    localparam logic [STEPS_W-1:0]    STEPS_RESET    = 3'd2;
    localparam logic [GLITCH_W-1:0]   GLITCH_RESET   = 8'd1;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd30;

    // Step directions
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_CW   = 2'd1;
    localparam logic [1:0] STEP_CCW  = 2'd2;

    typedef struct packed {
        logic [1:0] event_code;
        logic       event_pending;
    } result_t;

    // Decode a phase transition, {from, to}, each as {A, B}
    function automatic logic [1:0] step_decode(input logic [3:0] trans);
        logic [1:0] dir;
        unique case (trans)
            4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = STEP_CW;
            4'b0010, 4'b1011, 4'b1101, 4'b0100: dir = STEP_CCW;
            default:                            dir = STEP_NONE;
        endcase
        return dir;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qeeu_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qeeu_if: channel interfaces of the quadrature encoder event unit
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface qeeu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       phase_a;
    logic       phase_b;
    logic       switch_level;

    modport source (output valid, kind, phase_a, phase_b, switch_level, input ready);
    modport sink   (input valid, kind, phase_a, phase_b, switch_level, output ready);
endinterface

interface qeeu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       event_pending;

    modport source (output valid, event_code, event_pending, input ready);
    modport sink   (input valid, event_code, event_pending, output ready);
endinterface

interface qeeu_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [qeeu_pkg::CFG_IDX_W-1:0]     index;
    logic [qeeu_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/qeeu_out_buffer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qeeu_out_buffer: two-entry result stage
// Output register plus skid register, so a stalled result does not
// block the beat that follows it.
// ----------------------------------------------------------------------------
module qeeu_out_buffer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire qeeu_pkg::result_t push_data,
    output logic                   push_ready,
    qeeu_out_if.source             result
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    qeeu_pkg::result_t main_reg, main_next;
    qeeu_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign push_ready           = !skid_valid_reg;
    assign pop                  = main_valid_reg && result.ready;
    assign result.valid         = main_valid_reg;
    assign result.event_code    = main_reg.event_code;
    assign result.event_pending = main_reg.event_pending;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // drain the skid entry into the output register
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule
`default_nettype wire

// ===== rtl/quadrature_encoder_event_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_encoder_event_unit: rotary encoder and button event front end
// Ages glitch and debounce timers on ticks, decodes Gray-code encoder
// steps into detent events, debounces button presses, and holds one
// last event that a read beat returns and clears.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  item    | in  | valid / ready | kind, phase_a, phase_b, switch_level
//  result  | out | valid / ready | event_code, event_pending
//  cfg     | in  | valid / ready | index, data (always ready)
//
//  One item per cycle while item.ready is high. All state updates for a beat
//  happen at the edge that accepts it, which also registers its result.
//  A result stall while the output register is full parks the next beat in
//  the skid register and drops item.ready until the stalled result leaves.
//  Reset clears the working state, saturates both timers and loads the register defaults; no clearing pass.
//
module quadrature_encoder_event_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    qeeu_in_if.sink     item,
    qeeu_out_if.source  result,
    qeeu_cfg_if.sink    cfg
);

    // Configuration registers
    logic                                rot_enable_reg;
    logic [qeeu_pkg::STEPS_W-1:0]        steps_reg;
    logic [qeeu_pkg::GLITCH_W-1:0]       glitch_reg;
    logic [qeeu_pkg::DEBOUNCE_W-1:0]     debounce_reg;

    // Working state
    logic [1:0]                          phases_reg, phases_next;
    logic signed [qeeu_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [qeeu_pkg::ELAPSED_BITS-1:0]   enc_elapsed_reg, enc_elapsed_next;
    logic [qeeu_pkg::ELAPSED_BITS-1:0]   sw_elapsed_reg, sw_elapsed_next;
    logic                                latched_reg, latched_next;
    logic [1:0]                          stored_reg, stored_next;

    logic                                accept;
    logic                                push_ready;
    logic                                enc_open;
    logic                                sw_open;
    logic [1:0]                          phases_in;
    logic [1:0]                          step_dir;
    logic signed [qeeu_pkg::ACC_W:0]     acc_sum;
    logic signed [qeeu_pkg::ACC_W:0]     detent_pos;
    logic signed [qeeu_pkg::ACC_W:0]     detent_neg;
    qeeu_pkg::result_t                   res;

    assign item.ready = push_ready;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && push_ready;

    // Window checks: a saturated counter always counts as open
    assign enc_open = (enc_elapsed_reg == qeeu_pkg::ELAPSED_MAX)
                   || (qeeu_pkg::CMP_W'(enc_elapsed_reg) >= qeeu_pkg::CMP_W'(glitch_reg));
    assign sw_open  = (sw_elapsed_reg == qeeu_pkg::ELAPSED_MAX)
                   || (qeeu_pkg::CMP_W'(sw_elapsed_reg) >= qeeu_pkg::CMP_W'(debounce_reg));

    // Step decode and accumulator update
    assign phases_in  = {item.phase_a, item.phase_b};
    assign step_dir   = qeeu_pkg::step_decode({phases_reg, phases_in});
    assign acc_sum    = {acc_reg[qeeu_pkg::ACC_W-1], acc_reg}
                      + ((step_dir == qeeu_pkg::STEP_CW) ? 5'sd1 : -5'sd1);
    assign detent_pos = signed'({2'b00, steps_reg});
    assign detent_neg = -detent_pos;

    always_comb
    begin
        phases_next      = phases_reg;
        acc_next         = acc_reg;
        enc_elapsed_next = enc_elapsed_reg;
        sw_elapsed_next  = sw_elapsed_reg;
        latched_next     = latched_reg;
        stored_next      = stored_reg;
        res.event_code   = qeeu_pkg::EVT_EMPTY;

        unique case (item.kind)
            qeeu_pkg::KIND_TICK:
            begin
                // age both timers, holding at the top
                if (enc_elapsed_reg != qeeu_pkg::ELAPSED_MAX)
                begin
                    enc_elapsed_next = enc_elapsed_reg + qeeu_pkg::ELAPSED_BITS'(1);
                end
                if (sw_elapsed_reg != qeeu_pkg::ELAPSED_MAX)
                begin
                    sw_elapsed_next = sw_elapsed_reg + qeeu_pkg::ELAPSED_BITS'(1);
                end
            end
            qeeu_pkg::KIND_ENCODE:
            begin
                // drop edges while disabled or inside the glitch window
                if (rot_enable_reg && enc_open)
                begin
                    enc_elapsed_next = '0;
                    phases_next      = phases_in;
                    if (step_dir != qeeu_pkg::STEP_NONE)
                    begin
                        priority if (acc_sum >= detent_pos)
                        begin
                            acc_next    = '0;
                            stored_next = qeeu_pkg::EVT_CW;
                        end
                        else if (acc_sum <= detent_neg)
                        begin
                            acc_next    = '0;
                            stored_next = qeeu_pkg::EVT_CCW;
                        end
                        else
                        begin
                            acc_next = acc_sum[qeeu_pkg::ACC_W-1:0];
                        end
                    end
                end
            end
            qeeu_pkg::KIND_SWITCH:
            begin
                // release of a latched button clears at once, no debounce
                priority if (item.switch_level && latched_reg)
                begin
                    latched_next = 1'b0;
                end
                else if (sw_open)
                begin
                    sw_elapsed_next = '0;
                    if (!item.switch_level && !latched_reg)
                    begin
                        latched_next = 1'b1;
                        stored_next  = qeeu_pkg::EVT_BUTTON;
                    end
                end
                else
                begin
                    latched_next = latched_reg;
                end
            end
            qeeu_pkg::KIND_READ:
            begin
                // hand out the stored event and clear it
                res.event_code = stored_reg;
                stored_next    = qeeu_pkg::EVT_EMPTY;
            end
            default:
            begin
                res.event_code = qeeu_pkg::EVT_EMPTY;
            end
        endcase

        res.event_pending = (stored_next != qeeu_pkg::EVT_EMPTY);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_enable_reg <= 1'b0;
            steps_reg      <= qeeu_pkg::STEPS_RESET;
            glitch_reg     <= qeeu_pkg::GLITCH_RESET;
            debounce_reg   <= qeeu_pkg::DEBOUNCE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                qeeu_pkg::CFG_ROTATION_ENABLE:  rot_enable_reg <= cfg.data[0];
                qeeu_pkg::CFG_STEPS_PER_DETENT: steps_reg <= cfg.data[qeeu_pkg::STEPS_W-1:0];
                qeeu_pkg::CFG_GLITCH_TICKS:     glitch_reg <= cfg.data[qeeu_pkg::GLITCH_W-1:0];
                qeeu_pkg::CFG_DEBOUNCE_TICKS:
                    debounce_reg <= cfg.data[qeeu_pkg::DEBOUNCE_W-1:0];
                default:                        rot_enable_reg <= rot_enable_reg;
            endcase
        end
    end

    // Advance state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phases_reg      <= '0;
            acc_reg         <= '0;
            enc_elapsed_reg <= qeeu_pkg::ELAPSED_MAX;
            sw_elapsed_reg  <= qeeu_pkg::ELAPSED_MAX;
            latched_reg     <= 1'b0;
            stored_reg      <= qeeu_pkg::EVT_EMPTY;
        end
        else if (accept)
        begin
            phases_reg      <= phases_next;
            acc_reg         <= acc_next;
            enc_elapsed_reg <= enc_elapsed_next;
            sw_elapsed_reg  <= sw_elapsed_next;
            latched_reg     <= latched_next;
            stored_reg      <= stored_next;
        end
    end

    qeeu_out_buffer u_out_buffer (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (res),
        .push_ready (push_ready),
        .result     (result)
    );

endmodule
`default_nettype wire

// ===== sim/tb_quadrature_encoder_event_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_event_unit: self-checking bench for the encoder unit
// Sends tick, encoder, switch and read beats under several register settings
// and predicts every result beat from a scoreboard. The scoreboard tracks the
// detent accumulator, the glitch and debounce windows, the button latch and
// the stored event. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

class encoder_event_book;
    // register copies
    logic                              rot_en;
    logic [qeeu_pkg::STEPS_W-1:0]      detent;
    logic [qeeu_pkg::GLITCH_W-1:0]     glitch;
    logic [qeeu_pkg::DEBOUNCE_W-1:0]   debounce;
    // unit state
    logic [1:0]                        last_ab;
    int                                turn_acc;
    logic [qeeu_pkg::ELAPSED_BITS-1:0] enc_age;
    logic [qeeu_pkg::ELAPSED_BITS-1:0] sw_age;
    logic                              pressed;
    logic [1:0]                        held_evt;
    // result beats still to come, oldest first
    qeeu_pkg::result_t                 due[$];
    int                                errors;

    function new();
        rot_en   = 1'b0;
        detent   = qeeu_pkg::STEPS_RESET;
        glitch   = qeeu_pkg::GLITCH_RESET;
        debounce = qeeu_pkg::DEBOUNCE_RESET;
        last_ab  = 2'b00;
        turn_acc = 0;
        enc_age  = qeeu_pkg::ELAPSED_MAX;
        sw_age   = qeeu_pkg::ELAPSED_MAX;
        pressed  = 1'b0;
        held_evt = qeeu_pkg::EVT_EMPTY;
        errors   = 0;
    endfunction

    // position of a phase pair along the clockwise Gray cycle 00-01-11-10
    static function int gray_pos(logic [1:0] ab);
        case (ab)
            2'b00:   return 0;
            2'b01:   return 1;
            2'b11:   return 2;
            default: return 3;
        endcase
    endfunction

    static function logic [1:0] gray_at(int p);
        case (p & 3)
            0:       return 2'b00;
            1:       return 2'b01;
            2:       return 2'b11;
            default: return 2'b10;
        endcase
    endfunction

    // a saturated counter has passed any window
    static function bit window_open(logic [qeeu_pkg::ELAPSED_BITS-1:0] age, int window);
        return (age == qeeu_pkg::ELAPSED_MAX) || (int'(age) >= window);
    endfunction

    static function int ticks_to_open(logic [qeeu_pkg::ELAPSED_BITS-1:0] age, int window);
        if (window_open(age, window))
            return 0;
        return window - int'(age);
    endfunction

    function void set_reg(logic [qeeu_pkg::CFG_IDX_W-1:0] idx,
                          logic [qeeu_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            qeeu_pkg::CFG_ROTATION_ENABLE:  rot_en   = val[0];
            qeeu_pkg::CFG_STEPS_PER_DETENT: detent   = val[qeeu_pkg::STEPS_W-1:0];
            qeeu_pkg::CFG_GLITCH_TICKS:     glitch   = val[qeeu_pkg::GLITCH_W-1:0];
            default:                        debounce = val[qeeu_pkg::DEBOUNCE_W-1:0];
        endcase
    endfunction

    function void note_item(logic [1:0] kind, logic a, logic b, logic level);
        logic [1:0]        code;
        logic [1:0]        ab;
        int                dir;
        qeeu_pkg::result_t want;
        code = qeeu_pkg::EVT_EMPTY;
        ab   = {a, b};
        case (kind)
            qeeu_pkg::KIND_TICK:
            begin
                if (enc_age != qeeu_pkg::ELAPSED_MAX)
                    enc_age = enc_age + 1'b1;
                if (sw_age != qeeu_pkg::ELAPSED_MAX)
                    sw_age = sw_age + 1'b1;
            end
            qeeu_pkg::KIND_ENCODE:
            begin
                if (rot_en && window_open(enc_age, int'(glitch)))
                begin
                    enc_age = '0;
                    case ((gray_pos(ab) - gray_pos(last_ab)) & 3)
                        1:       dir = 1;
                        3:       dir = -1;
                        default: dir = 0;
                    endcase
                    last_ab = ab;
                    if (dir != 0)
                    begin
                        turn_acc = turn_acc + dir;
                        if (turn_acc >= int'(detent))
                        begin
                            turn_acc = 0;
                            held_evt = qeeu_pkg::EVT_CW;
                        end
                        else if (turn_acc <= -int'(detent))
                        begin
                            turn_acc = 0;
                            held_evt = qeeu_pkg::EVT_CCW;
                        end
                    end
                end
            end
            qeeu_pkg::KIND_SWITCH:
            begin
                // release of a latched button skips the debounce window
                if (level && pressed)
                    pressed = 1'b0;
                else if (window_open(sw_age, int'(debounce)))
                begin
                    sw_age = '0;
                    if (!level && !pressed)
                    begin
                        pressed  = 1'b1;
                        held_evt = qeeu_pkg::EVT_BUTTON;
                    end
                end
            end
            default:
            begin
                code     = held_evt;
                held_evt = qeeu_pkg::EVT_EMPTY;
            end
        endcase
        want.event_code    = code;
        want.event_pending = (held_evt != qeeu_pkg::EVT_EMPTY);
        due.push_back(want);
    endfunction

    function void check_result(qeeu_pkg::result_t got);
        qeeu_pkg::result_t want;
        if (due.size() == 0)
        begin
            errors++;
            $display("%0t: result beat with nothing due, actual code %0d pending %0d",
                     $time, got.event_code, got.event_pending);
            return;
        end
        want = due.pop_front();
        if (got.event_code !== want.event_code)
        begin
            errors++;
            $display("%0t: event_code expected %0d actual %0d",
                     $time, want.event_code, got.event_code);
        end
        if (got.event_pending !== want.event_pending)
        begin
            errors++;
            $display("%0t: event_pending expected %0d actual %0d",
                     $time, want.event_pending, got.event_pending);
        end
    endfunction
endclass

module tb_quadrature_encoder_event_unit;

    // Generous ceiling: worst-case idle bursts and stalls on every beat
    // stay far below this.
    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 24;
    // Longest run of ticks sent to wait out a window; edges inside a longer
    // window get dropped instead.
    localparam int WAIT_CAP    = 24;

    logic clk;
    logic rst_n;

    qeeu_in_if  item_ch ();
    qeeu_out_if result_ch ();
    qeeu_cfg_if cfg_ch ();

    encoder_event_book book;
    int                items_sent;
    bit                gaps_on;
    bit                stalls_on;
    bit                hold_request;

    quadrature_encoder_event_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the unit wedges or never returns a beat.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_quadrature_encoder_event_unit: errors");
        $finish;
    end

    // Check every result beat at the edge that accepts it. Outputs come from
    // registers, so the values seen here are the ones before the edge.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            book.check_result('{result_ch.event_code, result_ch.event_pending});
    end

    // Result sink: alternate ready stretches and random stalls; on request,
    // hold ready low long enough to back the unit up into its item input.
    initial
    begin : result_sink
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one item beat, optionally after an idle burst, and hold it until
    // accepted. Enter and leave at a falling edge, so valid gets at most one
    // update per step.
    task automatic send_item(input logic [1:0] kind, input logic a, input logic b,
                             input logic level);
        int gap;
        gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= kind;
        item_ch.phase_a      <= a;
        item_ch.phase_b      <= b;
        item_ch.switch_level <= level;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        book.note_item(kind, a, b, level);
        items_sent++;
        @(negedge clk);
    endtask

    // Tick beats carry random levels in the unused fields.
    task automatic send_ticks(input int count);
        repeat (count)
            send_item(qeeu_pkg::KIND_TICK, rand_bit(), rand_bit(), rand_bit());
    endtask

    // Send a read beat with random levels in the unused fields.
    task automatic send_read();
        send_item(qeeu_pkg::KIND_READ, rand_bit(), rand_bit(), rand_bit());
    endtask

    // Drop valid and wait until every due beat has come back, plus a margin
    // for the output register.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (book.due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Write all four registers, one beat each; call only while idle.
    task automatic apply_settings(input logic en, input int steps, input int glitch,
                                  input int debounce);
        logic [qeeu_pkg::CFG_IDX_W-1:0]  regs [4] = '{qeeu_pkg::CFG_ROTATION_ENABLE,
                                                      qeeu_pkg::CFG_STEPS_PER_DETENT,
                                                      qeeu_pkg::CFG_GLITCH_TICKS,
                                                      qeeu_pkg::CFG_DEBOUNCE_TICKS};
        logic [qeeu_pkg::CFG_DATA_W-1:0] vals [4];
        vals[0] = qeeu_pkg::CFG_DATA_W'(en);
        vals[1] = qeeu_pkg::CFG_DATA_W'(steps);
        vals[2] = qeeu_pkg::CFG_DATA_W'(glitch);
        vals[3] = qeeu_pkg::CFG_DATA_W'(debounce);
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            book.set_reg(regs[i], vals[i]);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int         phase_end;
        int         pick;
        int         dir;
        int         steps;
        int         wait_ticks;
        logic       en;
        int         detent;
        int         glitch;
        int         debounce;
        logic [1:0] ab;

        // Drive every input to a known value before the first edge.
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = qeeu_pkg::KIND_TICK;
        item_ch.phase_a      = 1'b0;
        item_ch.phase_b      = 1'b0;
        item_ch.switch_level = 1'b1;
        result_ch.ready      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = qeeu_pkg::CFG_ROTATION_ENABLE;
        cfg_ch.data          = '0;
        book                 = new();
        items_sent           = 0;
        gaps_on              = 1'b0;
        stalls_on            = 1'b0;
        hold_request         = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- Directed: reset settings, rotation still disabled ---
        send_item(qeeu_pkg::KIND_READ, 1'b0, 1'b0, 1'b0);      // nothing stored yet
        send_item(qeeu_pkg::KIND_ENCODE, 1'b1, 1'b1, 1'b0);    // dropped: rotation disabled
        send_item(qeeu_pkg::KIND_TICK, 1'b1, 1'b1, 1'b1);      // counters hold at saturation
        send_item(qeeu_pkg::KIND_SWITCH, 1'b0, 1'b0, 1'b0);    // press passes saturated window
        send_item(qeeu_pkg::KIND_SWITCH, 1'b0, 1'b0, 1'b0);    // press while latched
        send_item(qeeu_pkg::KIND_READ, 1'b0, 1'b0, 1'b0);      // button event, then cleared
        send_item(qeeu_pkg::KIND_SWITCH, 1'b0, 1'b0, 1'b1);    // release drops the latch
        send_item(qeeu_pkg::KIND_READ, 1'b0, 1'b0, 1'b0);

        // --- Directed: one step per detent, zero windows ---
        settle();
        apply_settings(1'b1, 1, 0, 0);
        send_item(qeeu_pkg::KIND_ENCODE, 1'b0, 1'b1, 1'b0);    // 00 -> 01 clockwise
        send_item(qeeu_pkg::KIND_READ, 1'b0, 1'b0, 1'b0);
        send_item(qeeu_pkg::KIND_ENCODE, 1'b1, 1'b0, 1'b0);    // two-bit jump, no step
        send_item(qeeu_pkg::KIND_ENCODE, 1'b1, 1'b0, 1'b0);    // same phases, no step
        send_item(qeeu_pkg::KIND_ENCODE, 1'b0, 1'b0, 1'b0);    // 10 -> 00 clockwise
        send_item(qeeu_pkg::KIND_ENCODE, 1'b1, 1'b0, 1'b0);    // counterclockwise overwrites
        send_item(qeeu_pkg::KIND_READ, 1'b0, 1'b0, 1'b0);
        send_item(qeeu_pkg::KIND_SWITCH, 1'b0, 1'b0, 1'b1);    // release while unlatched
        send_item(qeeu_pkg::KIND_SWITCH, 1'b0, 1'b0, 1'b0);    // press with zero debounce
        send_item(qeeu_pkg::KIND_ENCODE, 1'b1, 1'b1, 1'b0);    // rotation overwrites button
        send_item(qeeu_pkg::KIND_READ, 1'b0, 1'b0, 1'b0);

        // --- Directed: zero steps per detent ---
        settle();
        apply_settings(1'b1, 0, 0, 0);
        send_item(qeeu_pkg::KIND_ENCODE, 1'b0, 1'b1, 1'b0);    // 11 -> 01 counterclockwise
        send_item(qeeu_pkg::KIND_READ, 1'b0, 1'b0, 1'b0);
        send_item(qeeu_pkg::KIND_ENCODE, 1'b1, 1'b1, 1'b0);    // 01 -> 11 clockwise
        send_item(qeeu_pkg::KIND_READ, 1'b0, 1'b0, 1'b0);

        // --- Random phases, each under its own settings ---
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    en = 1'b1; detent = 4; glitch = 0;   debounce = 0;
                end
                1:
                begin
                    en = 1'b1; detent = 0; glitch = 1;   debounce = 1;
                end
                2:
                begin
                    en = 1'b1; detent = 7; glitch = 255; debounce = 2;
                end
                3:
                begin
                    en = 1'b0; detent = 1; glitch = 0;   debounce = 4;
                end
                4:
                begin
                    en = 1'b1; detent = 1; glitch = 0;   debounce = 1023;
                end
                default:
                begin
                    en       = ($urandom_range(0, 4) != 0);
                    detent   = $urandom_range(0, 7);
                    glitch   = $urandom_range(0, 6);
                    debounce = $urandom_range(0, 12);
                end
            endcase
            apply_settings(en, detent, glitch, debounce);

            // Idle at random in most phases; none at all at the end.
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (p == 5 || p == 10)
            begin
                // Back-pressure: flood items while the sink holds off.
                hold_request = 1'b1;
                gaps_on      = 1'b0;
            end
            if (p >= PHASES - 2)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 3)
                begin
                    // Turn: steps in one direction, each just past the glitch
                    // window, now and then one tick early or a repeat or jump.
                    dir   = $urandom_range(0, 1) ? 1 : -1;
                    steps = (book.glitch > 16) ? 1 : $urandom_range(1, int'(book.detent) + 2);
                    repeat (steps)
                    begin
                        wait_ticks = book.ticks_to_open(book.enc_age, int'(book.glitch));
                        pick = $urandom_range(0, 9);
                        if (pick == 0 && wait_ticks > 0)
                            wait_ticks--;
                        else if (pick == 1)
                            wait_ticks += $urandom_range(1, 3);
                        if (wait_ticks > WAIT_CAP)
                            wait_ticks = WAIT_CAP;
                        send_ticks(wait_ticks);
                        ab = book.gray_at(book.gray_pos(book.last_ab) + dir);
                        pick = $urandom_range(0, 11);
                        if (pick == 0)
                            ab = book.last_ab;
                        else if (pick == 1)
                            ab = ~book.last_ab;
                        send_item(qeeu_pkg::KIND_ENCODE, ab[1], ab[0], rand_bit());
                        if ($urandom_range(0, 3) == 0)
                            send_read();
                    end
                    send_read();
                end
                else if (pick <= 5)
                begin
                    // Button: wait out the debounce window, press, maybe press
                    // again while latched, release, maybe release again.
                    wait_ticks = book.ticks_to_open(book.sw_age, int'(book.debounce));
                    pick = $urandom_range(0, 9);
                    if (pick == 0 && wait_ticks > 0)
                        wait_ticks--;
                    else if (pick == 1)
                        wait_ticks += $urandom_range(1, 3);
                    if (wait_ticks > WAIT_CAP)
                        wait_ticks = WAIT_CAP;
                    send_ticks(wait_ticks);
                    send_item(qeeu_pkg::KIND_SWITCH, rand_bit(), rand_bit(), 1'b0);
                    send_ticks($urandom_range(0, 3));
                    if ($urandom_range(0, 3) == 0)
                        send_item(qeeu_pkg::KIND_SWITCH, rand_bit(), rand_bit(), 1'b0);
                    if ($urandom_range(0, 1) == 0)
                        send_read();
                    send_item(qeeu_pkg::KIND_SWITCH, rand_bit(), rand_bit(), 1'b1);
                    if ($urandom_range(0, 3) == 0)
                        send_item(qeeu_pkg::KIND_SWITCH, rand_bit(), rand_bit(), 1'b1);
                end
                else if (pick == 6)
                    send_read();
                else
                    // Noise: any kind, any levels.
                    send_item(2'($urandom_range(0, 3)), rand_bit(), rand_bit(), rand_bit());
            end
        end

        // Drain the last beats and let the output register empty.
        settle();
        if (book.errors == 0)
            $display("tb_quadrature_encoder_event_unit: clean");
        else
            $display("tb_quadrature_encoder_event_unit: errors");
        $finish;
    end

endmodule
`default_nettype wire
